// ===== rtl/mt64_pkg.sv =====
package mt64_pkg;

    localparam int N_WORDS = 312;
    localparam int M_OFF = 156;
    localparam int WORD_W = 64;
    localparam int ADDR_W = 9;

    localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SM_MUL1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SM_MUL2 = 64'h94D049BB133111EB;
    localparam logic [63:0] TW_MATRIX = 64'hB5026F5AA96619E9;
    localparam logic [63:0] TW_UPPER = 64'hFFFFFFFF80000000;
    localparam logic [63:0] TW_LOWER = 64'h000000007FFFFFFF;

    // datapath commands
    localparam logic [2:0] CMD_IDLE = 3'd0;
    localparam logic [2:0] CMD_SEED_INIT = 3'd1;
    localparam logic [2:0] CMD_SEED_STEP = 3'd2;
    localparam logic [2:0] CMD_TWIST_RD = 3'd3;
    localparam logic [2:0] CMD_TWIST_WR = 3'd4;
    localparam logic [2:0] CMD_DRAW_RD = 3'd5;
    localparam logic [2:0] CMD_DRAW_OUT = 3'd6;
    localparam logic [2:0] CMD_CLEAR = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [ADDR_W-1:0] idx;
    } mt64_cmd_t;

    typedef struct packed {
        logic seed_done;
        logic mul_done;
    } mt64_stat_t;

    function automatic logic [63:0] twist_one(logic [63:0] cur, logic [63:0] nxt,
                                              logic [63:0] far);
        logic [63:0] y;
        logic [63:0] v;
        y = (cur & TW_UPPER) | (nxt & TW_LOWER);
        v = far ^ (y >> 1);
        if (y[0])
        begin
            v = v ^ TW_MATRIX;
        end
        return v;
    endfunction

    function automatic logic [63:0] temper(logic [63:0] y_in);
        logic [63:0] y;
        y = y_in;
        y = y ^ ((y >> 29) & 64'h5555555555555555);
        y = y ^ ((y << 17) & 64'h71D67FFFEDA60000);
        y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
        y = y ^ (y >> 43);
        return y;
    endfunction

endpackage

// ===== rtl/mt64_ram.sv =====
module mt64_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 312
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ===== rtl/mt64_mul.sv =====
// 64x64 low-half product, accumulated from four 16-bit multiplier slices
module mt64_mul
    import mt64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [2:0]  cnt_reg;
    logic [79:0] part;

    // a times one 16-bit slice of b, shifted into place
    always_comb
    begin
        part = a_reg * b_reg[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else if (start)
        begin
            cnt_reg <= 3'd4;
        end
        else if (cnt_reg != 3'd0)
        begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            acc_reg <= 64'd0;
        end
        else if (cnt_reg != 3'd0)
        begin
            acc_reg <= acc_reg + part[63:0];
            a_reg <= a_reg << 16;
            b_reg <= b_reg >> 16;
        end
    end

    assign done = (cnt_reg == 3'd1);
    assign p = acc_reg + part[63:0];
endmodule

// ===== rtl/mt64_dp.sv =====
module mt64_dp
    import mt64_pkg::*;
#(
    parameter int N = N_WORDS,
    parameter int M = M_OFF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mt64_cmd_t         cmd,
    input  logic [63:0]       seed_value,
    output mt64_stat_t        stat,
    output logic [63:0]       word_out
);
    localparam int AW = $clog2(N);

    logic [63:0] s_reg;
    logic [1:0]  sph_reg;
    logic [63:0] z_reg;
    logic        mstart;
    logic [63:0] ma;
    logic [63:0] mb;
    logic        mdone;
    logic [63:0] mp;

    logic          we;
    logic [AW-1:0] waddr;
    logic [63:0]   wdata;
    logic [AW-1:0] ra;
    logic [AW-1:0] rb;
    logic [63:0]   da;
    logic [63:0]   db;
    logic [63:0]   cur_reg;
    logic [AW-1:0] nidx;
    logic [AW-1:0] fidx;
    logic [63:0]   z_fin;

    mt64_ram #(.WIDTH(64), .DEPTH(N)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(ra), .rdata_a(da), .raddr_b(rb), .rdata_b(db)
    );

    mt64_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp)
    );

    assign nidx = (cmd.idx == AW'(N - 1)) ? '0 : cmd.idx + AW'(1);
    assign fidx = (cmd.idx < AW'(N - M)) ? cmd.idx + AW'(M) : cmd.idx - AW'(N - M);
    assign z_fin = mp ^ (mp >> 31);

    // seed word phases: 2 start, 0 first multiply, 1 second multiply
    always_comb
    begin
        mstart = 1'b0;
        ma = z_reg ^ (z_reg >> 30);
        mb = SM_MUL1;
        if (cmd.op == CMD_SEED_STEP && sph_reg == 2'd2)
        begin
            mstart = 1'b1;
        end
        else if (cmd.op == CMD_SEED_STEP && sph_reg == 2'd0 && mdone)
        begin
            mstart = 1'b1;
            ma = mp ^ (mp >> 27);
            mb = SM_MUL2;
        end
    end

    always_comb
    begin
        we = 1'b0;
        waddr = cmd.idx;
        wdata = 64'd0;
        ra = cmd.idx;
        rb = nidx;
        case (cmd.op)
            CMD_CLEAR:
            begin
                we = 1'b1;
            end
            CMD_SEED_STEP:
            begin
                we = (sph_reg == 2'd1) && mdone;
                wdata = z_fin;
            end
            CMD_TWIST_RD:
            begin
                ra = fidx;
            end
            CMD_TWIST_WR:
            begin
                we = 1'b1;
                ra = nidx;
                wdata = twist_one(cur_reg, db, da);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sph_reg <= 2'd2;
        end
        else if (cmd.op == CMD_SEED_INIT)
        begin
            sph_reg <= 2'd2;
        end
        else if (cmd.op == CMD_SEED_STEP)
        begin
            if (sph_reg == 2'd2)
            begin
                sph_reg <= 2'd0;
            end
            else if (mdone)
            begin
                sph_reg <= (sph_reg == 2'd0) ? 2'd1 : 2'd2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_SEED_INIT)
        begin
            s_reg <= seed_value + SM_GAMMA;
            z_reg <= seed_value + SM_GAMMA;
        end
        else if (cmd.op == CMD_SEED_STEP && sph_reg == 2'd1 && mdone)
        begin
            s_reg <= s_reg + SM_GAMMA;
            z_reg <= s_reg + SM_GAMMA;
        end
        // current word is read one step ahead in the twist
        if (cmd.op == CMD_DRAW_RD || cmd.op == CMD_TWIST_RD)
        begin
            cur_reg <= da;
        end
    end

    // current word arrives from the registered table read, in the cycle after the draw read
    assign word_out = da;
    assign stat.seed_done = (cmd.op == CMD_SEED_STEP) && (sph_reg == 2'd1) && mdone;
    assign stat.mul_done = mdone;
endmodule

// ===== rtl/mt64_ctrl.sv =====
module mt64_ctrl
    import mt64_pkg::*;
#(
    parameter int N = N_WORDS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_func,
    output logic        in_stall,
    input  mt64_stat_t  stat,
    input  logic        out_free,
    output mt64_cmd_t   cmd,
    output logic        load_out
);
    localparam int AW = $clog2(N);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SEED = 3'd2;
    localparam logic [2:0] S_TRD = 3'd3;
    localparam logic [2:0] S_TWR = 3'd4;
    localparam logic [2:0] S_DRD = 3'd5;
    localparam logic [2:0] S_DOUT = 3'd6;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [AW:0]   pos_reg;
    logic [AW:0]   pos_next;
    logic          last;

    assign last = (idx_reg == AW'(N - 1));
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        cmd.op = CMD_IDLE;
        cmd.idx = idx_reg;
        load_out = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = CMD_CLEAR;
                idx_next = last ? '0 : idx_reg + AW'(1);
                if (last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = '0;
                    if (in_func)
                    begin
                        cmd.op = CMD_SEED_INIT;
                        state_next = S_SEED;
                    end
                    else if (pos_reg >= (AW+1)'(N))
                    begin
                        state_next = S_TRD;
                    end
                    else
                    begin
                        state_next = S_DRD;
                    end
                end
            end
            S_SEED:
            begin
                cmd.op = CMD_SEED_STEP;
                if (stat.seed_done)
                begin
                    idx_next = last ? '0 : idx_reg + AW'(1);
                    if (last)
                    begin
                        pos_next = (AW+1)'(N);
                        state_next = S_IDLE;
                    end
                end
            end
            S_TRD:
            begin
                cmd.op = CMD_TWIST_RD;
                state_next = S_TWR;
            end
            S_TWR:
            begin
                cmd.op = CMD_TWIST_WR;
                idx_next = last ? '0 : idx_reg + AW'(1);
                if (last)
                begin
                    pos_next = '0;
                    state_next = S_DRD;
                end
                else
                begin
                    state_next = S_TRD;
                end
            end
            S_DRD:
            begin
                cmd.op = CMD_DRAW_RD;
                cmd.idx = pos_reg[AW-1:0];
                state_next = S_DOUT;
            end
            S_DOUT:
            begin
                cmd.op = CMD_DRAW_OUT;
                cmd.idx = pos_reg[AW-1:0];
                if (out_free)
                begin
                    load_out = 1'b1;
                    pos_next = pos_reg + (AW+1)'(1);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg <= '0;
            pos_reg <= (AW+1)'(N);
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            pos_reg <= pos_next;
        end
    end
endmodule

// ===== rtl/mersenne_twister_64_prng.sv =====
// 64-bit Mersenne Twister random source with splitmix64 seeding.
// Input channel (in_valid/in_stall): func 1 reseeds the 312-word table from
// seed_value and gives no result; func 0 draws one tempered 64-bit value.
// Output channel (out_valid/out_stall): one result per draw, held in an
// output register until taken; a new request is accepted while it waits.
// A draw goes through a read state and an output state into the output
// register; one item is worked at a time, so requests wait while it runs.
// When the table is used up, the draw first twists all 312 words, each in
// a read state and a write state over the dual-read table memory.
// A reseed works word by word, each word taking two 64-bit products, each
// made of four 16-bit slices.
// After reset the block clears all 312 table words to zero with in_stall
// high; draws before any seed then return zero.
// While the receiver stalls with a result still pending, a finished draw
// waits inside the block and in_stall stays high.
module mersenne_twister_64_prng
    import mt64_pkg::*;
#(
    parameter int N = N_WORDS,
    parameter int M = M_OFF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [63:0] seed_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] random_value
);
    mt64_cmd_t  cmd;
    mt64_stat_t stat;
    logic       load_out;
    logic       out_free;
    logic [63:0] word;
    logic        ov_reg;
    logic [63:0] rv_reg;

    assign out_free = !ov_reg || !out_stall;

    mt64_ctrl #(.N(N)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_func(func),
        .in_stall(in_stall), .stat(stat), .out_free(out_free), .cmd(cmd),
        .load_out(load_out)
    );

    mt64_dp #(.N(N), .M(M)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .seed_value(seed_value),
        .stat(stat), .word_out(word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (load_out)
        begin
            ov_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rv_reg <= temper(word);
        end
    end

    assign out_valid = ov_reg;
    assign random_value = rv_reg;
endmodule

// ===== verif/tb_mersenne_twister_64_prng.sv =====
module tb_mersenne_twister_64_prng
    import mt64_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM = 1410;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    typedef enum logic { FUNC_DRAW = 1'b0, FUNC_SEED = 1'b1 } func_e;

    typedef struct {
        func_e       fn;
        logic [63:0] seed;
        bit          known;
        logic [63:0] want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [63:0] seed_value;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] random_value;

    logic [63:0] mt_table [N_WORDS];
    int          mt_pos;
    logic [63:0] draw_queue [$];
    int          error_count;
    longint      cycle_count;
    int          stall_phase;

    stim_row_t   stim_rows [$];

    mersenne_twister_64_prng u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic logic [63:0] mix_word(logic [63:0] s);
        logic [63:0] z;
        z = s;
        z = (z ^ (z >> 30)) * 64'hBF58476D1CE4E5B9;
        z = (z ^ (z >> 27)) * 64'h94D049BB133111EB;
        return z ^ (z >> 31);
    endfunction

    function automatic logic [63:0] twist_word(logic [63:0] cur, logic [63:0] nxt,
                                               logic [63:0] far);
        logic [63:0] y;
        logic [63:0] v;
        y = {cur[63:31], nxt[30:0]};
        v = far ^ (y >> 1);
        if (y[0])
        begin
            v = v ^ 64'hB5026F5AA96619E9;
        end
        return v;
    endfunction

    function automatic logic [63:0] temper_word(logic [63:0] y_in);
        logic [63:0] y;
        y = y_in;
        y = y ^ ((y >> 29) & 64'h5555555555555555);
        y = y ^ ((y << 17) & 64'h71D67FFFEDA60000);
        y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
        y = y ^ (y >> 43);
        return y;
    endfunction

    // returns 1 and the drawn word when the request makes a result
    function automatic bit predict_request(func_e fn, logic [63:0] seed,
                                           output logic [63:0] drawn);
        logic [63:0] s;
        drawn = '0;
        if (fn == FUNC_SEED)
        begin
            s = seed;
            for (int k = 0; k < N_WORDS; k++)
            begin
                s = s + 64'h9E3779B97F4A7C15;
                mt_table[k] = mix_word(s);
            end
            mt_pos = N_WORDS;
            return 1'b0;
        end
        if (mt_pos >= N_WORDS)
        begin
            for (int k = 0; k < N_WORDS; k++)
            begin
                mt_table[k] = twist_word(mt_table[k], mt_table[(k + 1) % N_WORDS],
                                         mt_table[(k + M_OFF) % N_WORDS]);
            end
            mt_pos = 0;
        end
        drawn = temper_word(mt_table[mt_pos]);
        mt_pos++;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    task automatic send_request(func_e fn, logic [63:0] seed);
        in_valid   <= 1'b1;
        func       <= fn;
        seed_value <= seed;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic push_row(func_e fn, logic [63:0] seed, bit known, logic [63:0] want);
        stim_row_t r;
        r.fn = fn;
        r.seed = seed;
        r.known = known;
        r.want = want;
        stim_rows.push_back(r);
    endtask

    // receiver and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && !out_stall)
            begin
                if (draw_queue.size() == 0)
                begin
                    report_mismatch("unexpected result", random_value, '0);
                end
                else
                begin
                    if (random_value !== draw_queue[0])
                    begin
                        report_mismatch("random_value", random_value, draw_queue[0]);
                    end
                    void'(draw_queue.pop_front());
                end
            end
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 64) % 4)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [63:0] drawn;
        logic [63:0] rseed;
        int          gap;
        int          burst;
        int          draws;
        bit          made;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = 1'b0;
        seed_value  = '0;
        out_stall   = 1'b0;
        error_count = 0;
        cycle_count = 0;
        stall_phase = 0;
        for (int k = 0; k < N_WORDS; k++)
        begin
            mt_table[k] = '0;
        end
        mt_pos = N_WORDS;

        // unseeded draws read zero; seed field ignored on a draw
        push_row(FUNC_DRAW, '0, 1'b1, '0);
        push_row(FUNC_DRAW, '1, 1'b1, '0);
        push_row(FUNC_DRAW, 64'hA5A5A5A55A5A5A5A, 1'b1, '0);
        push_row(FUNC_SEED, '0, 1'b0, '0);
        push_row(FUNC_DRAW, '0, 1'b0, '0);
        push_row(FUNC_DRAW, '1, 1'b0, '0);
        push_row(FUNC_SEED, '1, 1'b0, '0);
        push_row(FUNC_DRAW, '0, 1'b0, '0);
        push_row(FUNC_DRAW, '0, 1'b0, '0);
        push_row(FUNC_SEED, 64'h0000000000000001, 1'b0, '0);
        push_row(FUNC_SEED, 64'h8000000000000000, 1'b0, '0);
        push_row(FUNC_DRAW, 64'h5555555555555555, 1'b0, '0);
        push_row(FUNC_DRAW, 64'hAAAAAAAAAAAAAAAA, 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            made = predict_request(stim_rows[i].fn, stim_rows[i].seed, drawn);
            if (made)
            begin
                draw_queue.push_back(stim_rows[i].known ? stim_rows[i].want : drawn);
            end
            send_request(stim_rows[i].fn, stim_rows[i].seed);
            in_valid <= 1'b0;
            @(posedge clk);
        end

        // a full table of draws plus a few crosses the twist boundary
        for (int i = 0; i < 320; i++)
        begin
            made = predict_request(FUNC_DRAW, '0, drawn);
            draw_queue.push_back(drawn);
            send_request(FUNC_DRAW, {$urandom, $urandom});
        end

        draws = 0;
        while (draws < NUM_RANDOM)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++)
            begin
                // reseeds are slow, keep them rare
                if ($urandom_range(0, 199) == 0)
                begin
                    rseed = {$urandom, $urandom};
                    made = predict_request(FUNC_SEED, rseed, drawn);
                    send_request(FUNC_SEED, rseed);
                end
                else
                begin
                    rseed = {$urandom, $urandom};
                    made = predict_request(FUNC_DRAW, rseed, drawn);
                    draw_queue.push_back(drawn);
                    send_request(FUNC_DRAW, rseed);
                    draws++;
                end
            end
        end
        in_valid <= 1'b0;

        while (draw_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);

        if (error_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== mersenne_twister_64_prng.f =====
rtl/mt64_pkg.sv
rtl/mt64_ram.sv
rtl/mt64_mul.sv
rtl/mt64_dp.sv
rtl/mt64_ctrl.sv
rtl/mersenne_twister_64_prng.sv
verif/tb_mersenne_twister_64_prng.sv
